>>> hdl/crg_pkg.sv
// ----------------------------------------------------------------------------
// crg_pkg: shared definitions for the circle raster generator
// Operation codes, mode codes, per-result selection table and the job
// control word passed from the step unit to the result emitter.
// ----------------------------------------------------------------------------
package crg_pkg;

  localparam int COORD_WIDTH_DEF  = 16;
  localparam int RADIUS_WIDTH_DEF = 14;

  // operation codes
  localparam logic OP_START = 1'b0;
  localparam logic OP_STEP  = 1'b1;

  // fill_mode codes
  localparam logic MODE_OUTLINE = 1'b0;
  localparam logic MODE_FILL    = 1'b1;

  // result index within one iteration
  localparam int IDX_W = 3;
  localparam logic [IDX_W-1:0] OUTLINE_LAST = 3'd7;
  localparam logic [IDX_W-1:0] FILL_LAST    = 3'd3;

  typedef struct packed {
    logic valid;  // an iteration waits to be emitted
    logic fill;   // mode latched when the item arrived
    logic done;   // this iteration finishes the circle
  } job_ctl_t;

  typedef struct packed {
    logic x_use_oy;  // x offset is offset_y, y offset is offset_x
    logic x_neg;     // point x lies left of the center
    logic y_neg;     // row lies above the center
    logic span;      // x_start/x_end run from center-xo to center+xo
  } res_sel_t;

  function automatic res_sel_t result_sel(input logic fill, input logic [IDX_W-1:0] idx);
    res_sel_t s;
    if (fill == MODE_FILL) begin
      s.x_use_oy = (idx[0] == idx[1]);
      s.x_neg    = 1'b1;
      s.y_neg    = idx[1];
      s.span     = 1'b1;
    end else begin
      s.x_use_oy = idx[0];
      s.x_neg    = idx[1];
      s.y_neg    = idx[2];
      s.span     = 1'b0;
    end
    return s;
  endfunction

endpackage

>>> hdl/crg_step.sv
// ----------------------------------------------------------------------------
// crg_step: circle state and Andres step
// Takes input words, holds center, offsets and decision term, applies one
// Andres update per emitting word and hands the iteration to the emitter.
// ----------------------------------------------------------------------------
module crg_step #(
  parameter int COORD_WIDTH  = crg_pkg::COORD_WIDTH_DEF,
  parameter int RADIUS_WIDTH = crg_pkg::RADIUS_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_write_en,
  input  logic                          cfg_write_data,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          operation,
  input  logic signed [COORD_WIDTH-1:0] center_x,
  input  logic signed [COORD_WIDTH-1:0] center_y,
  input  logic        [RADIUS_WIDTH-1:0] radius,
  output crg_pkg::job_ctl_t             job_ctl,
  output logic signed [COORD_WIDTH-1:0] job_cx,
  output logic signed [COORD_WIDTH-1:0] job_cy,
  output logic        [RADIUS_WIDTH:0]  job_ox,
  output logic        [RADIUS_WIDTH:0]  job_oy,
  input  logic                          job_take,
  output logic                          active
);

  localparam int OW = RADIUS_WIDTH + 1;  // offset width
  localparam int DW = RADIUS_WIDTH + 3;  // decision width
  localparam int EW = RADIUS_WIDTH + 4;  // decision arithmetic width

  logic                          fill_mode;
  logic signed [COORD_WIDTH-1:0] center_x_reg;
  logic signed [COORD_WIDTH-1:0] center_y_reg;
  logic        [RADIUS_WIDTH-1:0] radius_reg;
  logic        [OW-1:0]          offset_x;
  logic        [OW-1:0]          offset_y;
  logic signed [DW-1:0]          decision;

  logic                          in_fire;
  logic                          start;
  logic signed [COORD_WIDTH-1:0] cx_cur;
  logic signed [COORD_WIDTH-1:0] cy_cur;
  logic        [RADIUS_WIDTH-1:0] r_cur;
  logic        [OW-1:0]          ox_cur;
  logic        [OW-1:0]          oy_cur;
  logic                          act_cur;
  logic                          run;

  logic signed [EW-1:0] d_e;
  logic signed [EW-1:0] ox_e;
  logic signed [EW-1:0] oy_e;
  logic signed [EW-1:0] r_e;
  logic signed [EW-1:0] d_wide;
  logic        [OW-1:0] offset_x_next;
  logic        [OW-1:0] offset_y_next;
  logic signed [DW-1:0] decision_next;
  logic                 oy_wrap;
  logic                 circle_end;

  assign in_fire = in_valid && in_ready;
  assign start   = (operation == crg_pkg::OP_START);
  assign in_ready = !job_ctl.valid || job_take;

  always_comb begin
    if (start) begin
      cx_cur  = center_x;
      cy_cur  = center_y;
      r_cur   = radius;
      ox_cur  = '0;
      oy_cur  = OW'(radius);
      d_e     = EW'(radius) - EW'(1);
      act_cur = 1'b1;
    end else begin
      cx_cur  = center_x_reg;
      cy_cur  = center_y_reg;
      r_cur   = radius_reg;
      ox_cur  = offset_x;
      oy_cur  = offset_y;
      d_e     = EW'(decision);
      act_cur = active;
    end
  end

  assign run  = act_cur && (oy_cur >= ox_cur);
  assign ox_e = EW'(ox_cur);
  assign oy_e = EW'(oy_cur);
  assign r_e  = EW'(r_cur);

  // Andres update: step right, step down, or step diagonally
  always_comb begin
    if (d_e >= (ox_e <<< 1)) begin
      d_wide        = d_e - (ox_e <<< 1) - EW'(1);
      offset_x_next = ox_cur + OW'(1);
      offset_y_next = oy_cur;
    end else if (d_e < ((r_e - oy_e) <<< 1)) begin
      d_wide        = d_e + (oy_e <<< 1) - EW'(1);
      offset_x_next = ox_cur;
      offset_y_next = oy_cur - OW'(1);
    end else begin
      d_wide        = d_e + ((oy_e - ox_e - EW'(1)) <<< 1);
      offset_x_next = ox_cur + OW'(1);
      offset_y_next = oy_cur - OW'(1);
    end
    decision_next = DW'(d_wide);
  end

  // a zero radius steps offset_y below zero, which ends the circle
  assign oy_wrap    = (oy_cur == '0) && (offset_y_next != '0);
  assign circle_end = (offset_y_next < offset_x_next) || oy_wrap;

  always_ff @(posedge clk) begin
    if (rst) begin
      fill_mode   <= crg_pkg::MODE_OUTLINE;
      active      <= 1'b0;
      job_ctl     <= '0;
    end else begin
      if (cfg_write_en) begin
        fill_mode <= cfg_write_data;
      end
      if (in_fire && run) begin
        active        <= !circle_end;
        job_ctl.valid <= 1'b1;
        job_ctl.fill  <= fill_mode;
        job_ctl.done  <= circle_end;
      end else begin
        if (in_fire) begin
          active <= 1'b0;
        end
        if (job_take) begin
          job_ctl.valid <= 1'b0;
        end
      end
    end
  end

  // payload: no reset needed, active guards every use
  always_ff @(posedge clk) begin
    if (in_fire && run) begin
      center_x_reg <= cx_cur;
      center_y_reg <= cy_cur;
      radius_reg   <= r_cur;
      offset_x     <= offset_x_next;
      offset_y     <= offset_y_next;
      decision     <= decision_next;
      job_cx       <= cx_cur;
      job_cy       <= cy_cur;
      job_ox       <= ox_cur;
      job_oy       <= oy_cur;
    end
  end

endmodule

>>> hdl/crg_emit.sv
// ----------------------------------------------------------------------------
// crg_emit: result emitter
// Walks the points or spans of one iteration, one result word per cycle
// while the output register is free or drained by out_ready, into that register.
// ----------------------------------------------------------------------------
module crg_emit #(
  parameter int COORD_WIDTH  = crg_pkg::COORD_WIDTH_DEF,
  parameter int RADIUS_WIDTH = crg_pkg::RADIUS_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  crg_pkg::job_ctl_t             job_ctl,
  input  logic signed [COORD_WIDTH-1:0] job_cx,
  input  logic signed [COORD_WIDTH-1:0] job_cy,
  input  logic        [RADIUS_WIDTH:0]  job_ox,
  input  logic        [RADIUS_WIDTH:0]  job_oy,
  output logic                          job_take,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic signed [COORD_WIDTH:0]   x_start,
  output logic signed [COORD_WIDTH:0]   x_end,
  output logic signed [COORD_WIDTH:0]   y_coord,
  output logic                          last_of_step,
  output logic                          circle_done
);

  localparam int PW = COORD_WIDTH + 1;

  logic [crg_pkg::IDX_W-1:0] idx;
  logic [crg_pkg::IDX_W-1:0] last_idx;
  crg_pkg::res_sel_t         sel;
  logic                      slot_free;
  logic                      load;
  logic                      is_last;
  logic        [RADIUS_WIDTH:0] xo;
  logic        [RADIUS_WIDTH:0] yo;
  logic signed [PW-1:0]      cx_w;
  logic signed [PW-1:0]      cy_w;
  logic signed [PW-1:0]      xo_w;
  logic signed [PW-1:0]      yo_w;
  logic signed [PW-1:0]      x_lo;
  logic signed [PW-1:0]      x_hi;
  logic signed [PW-1:0]      x_start_next;
  logic signed [PW-1:0]      x_end_next;
  logic signed [PW-1:0]      y_next;

  assign last_idx  = job_ctl.fill ? crg_pkg::FILL_LAST : crg_pkg::OUTLINE_LAST;
  assign sel       = crg_pkg::result_sel(job_ctl.fill, idx);
  assign slot_free = !out_valid || out_ready;
  assign load      = job_ctl.valid && slot_free;
  assign is_last   = (idx == last_idx);
  assign job_take  = load && is_last;

  assign xo   = sel.x_use_oy ? job_oy : job_ox;
  assign yo   = sel.x_use_oy ? job_ox : job_oy;
  assign cx_w = PW'(job_cx);
  assign cy_w = PW'(job_cy);
  assign xo_w = PW'(xo);
  assign yo_w = PW'(yo);
  assign x_lo = cx_w - xo_w;
  assign x_hi = cx_w + xo_w;

  assign x_start_next = (sel.span || sel.x_neg) ? x_lo : x_hi;
  assign x_end_next   = sel.span ? x_hi : x_start_next;
  assign y_next       = sel.y_neg ? (cy_w - yo_w) : (cy_w + yo_w);

  always_ff @(posedge clk) begin
    if (rst) begin
      idx       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (load) begin
        out_valid <= 1'b1;
        idx       <= is_last ? '0 : idx + 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      x_start      <= x_start_next;
      x_end        <= x_end_next;
      y_coord      <= y_next;
      last_of_step <= is_last;
      circle_done  <= is_last && job_ctl.done;
    end
  end

endmodule

>>> hdl/circle_raster_generator_unit.sv
// ----------------------------------------------------------------------------
// circle_raster_generator_unit: integer circle rasterizer, top level
// Turns start and step words into outline points or fill spans.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready): operation 0 loads center and radius
//   and emits the first iteration; operation 1 emits the next iteration.
//   A step after the circle is finished, or before any start, emits nothing.
//   Output channel (out_valid/out_ready): one word per point (outline mode,
//   eight per iteration) or per horizontal span (fill mode, four per
//   iteration). last_of_step marks the final word of an iteration and
//   circle_done marks it when the circle is complete.
//   Configuration: cfg_write_en writes fill_mode from cfg_write_data; write
//   it only while the block is idle. Each iteration keeps the mode that was
//   set when its input word arrived.
//   Timing: the first result word passes the iteration register in the step
//   unit and then the output register before it is presented. Throughput:
//   one result word per cycle while out_ready is high; a new input word is
//   taken in the cycle the last word of the current iteration loads, so
//   eight result words per input word in outline mode and four in fill mode.
//   A word that emits nothing yields no iteration and no result word.
//   Reset: no circle in progress, outline mode, output empty.
//   Stall: when out_ready is low while out_valid is high, the result register
//   holds, the emitter holds its iteration, and in_ready drops until the iteration is drained.
// ----------------------------------------------------------------------------
module circle_raster_generator_unit #(
  parameter int COORD_WIDTH  = crg_pkg::COORD_WIDTH_DEF,
  parameter int RADIUS_WIDTH = crg_pkg::RADIUS_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_write_en,
  input  logic                          cfg_write_data,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          operation,
  input  logic signed [COORD_WIDTH-1:0] center_x,
  input  logic signed [COORD_WIDTH-1:0] center_y,
  input  logic        [RADIUS_WIDTH-1:0] radius,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic signed [COORD_WIDTH:0]   x_start,
  output logic signed [COORD_WIDTH:0]   x_end,
  output logic signed [COORD_WIDTH:0]   y_coord,
  output logic                          last_of_step,
  output logic                          circle_done
);

  // iteration handed from the step unit to the emitter
  crg_pkg::job_ctl_t             job_ctl;
  logic signed [COORD_WIDTH-1:0] job_cx;
  logic signed [COORD_WIDTH-1:0] job_cy;
  logic        [RADIUS_WIDTH:0]  job_ox;
  logic        [RADIUS_WIDTH:0]  job_oy;
  logic                          job_take;
  logic                          active;

  // state update: one Andres step per emitting word
  crg_step #(
    .COORD_WIDTH  (COORD_WIDTH),
    .RADIUS_WIDTH (RADIUS_WIDTH)
  ) u_step (
    .clk            (clk),
    .rst            (rst),
    .cfg_write_en   (cfg_write_en),
    .cfg_write_data (cfg_write_data),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .operation      (operation),
    .center_x       (center_x),
    .center_y       (center_y),
    .radius         (radius),
    .job_ctl        (job_ctl),
    .job_cx         (job_cx),
    .job_cy         (job_cy),
    .job_ox         (job_ox),
    .job_oy         (job_oy),
    .job_take       (job_take),
    .active         (active)
  );

  // result sequencing: walk the iteration into the output register
  crg_emit #(
    .COORD_WIDTH  (COORD_WIDTH),
    .RADIUS_WIDTH (RADIUS_WIDTH)
  ) u_emit (
    .clk          (clk),
    .rst          (rst),
    .job_ctl      (job_ctl),
    .job_cx       (job_cx),
    .job_cy       (job_cy),
    .job_ox       (job_ox),
    .job_oy       (job_oy),
    .job_take     (job_take),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .x_start      (x_start),
    .x_end        (x_end),
    .y_coord      (y_coord),
    .last_of_step (last_of_step),
    .circle_done  (circle_done)
  );

  // a start always yields an iteration to emit
  a_start_emits: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready && (operation == crg_pkg::OP_START)) |=> job_ctl.valid)
    else $error("start word produced no iteration");

  // hold the iteration until its last word leaves the emitter
  a_job_held: assert property (@(posedge clk) disable iff (rst)
    (job_ctl.valid && !job_take) |=> job_ctl.valid)
    else $error("iteration dropped before fully emitted");

  // a step word on an idle circle leaves no circle active
  a_done_clears: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready && (operation == crg_pkg::OP_STEP) && !active) |=> !active)
    else $error("step word revived an idle circle");

  // the done flag rides only on the last word of an iteration
  a_done_last: assert property (@(posedge clk) disable iff (rst)
    (out_valid && circle_done) |-> last_of_step)
    else $error("circle_done outside the last word of an iteration");

endmodule
